// ===== rtl/core/bpl_pkg.sv =====
// ----------------------------------------------------------------------------
// BSP point locate: shared package
// Types and fixed constants of the point location block: the node entry
// layout, child reference coding, item functions and the control and status
// words passed between the sequencer and the side unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bpl_pkg;

	localparam int COORD_W = 32;
	localparam int REF_W   = 16;
	localparam int LEAF_W  = 15;
	localparam int ENTRY_W = 12;
	localparam int INT_W   = 16;
	localparam int FRAC_W  = 16;

	// Bit 15 of a child reference marks a leaf; the low 15 bits hold its index.
	localparam int LEAF_BIT = 15;

	localparam logic [REF_W-1:0] ROOT_RESET = 16'h8000;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_LOCATE = 1'b1;

	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-1:0] REG_ROOT = 2'd0;

	typedef struct packed {
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] delta_x;
		logic signed [COORD_W-1:0] delta_y;
		logic [REF_W-1:0]          front_ref;
		logic [REF_W-1:0]          back_ref;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	// Sequencer steps that drive the side unit.
	typedef struct packed {
		logic eval;
		logic mul_first;
		logic mul_second;
	} side_ctl_t;

	// direct: the side is settled in the evaluate step without products.
	typedef struct packed {
		logic direct;
		logic side;
	} side_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/bpl_if.sv =====
// ----------------------------------------------------------------------------
// BSP point locate: channel interfaces
// Valid/ready channels for input words (node writes and point queries) and
// for result words (leaf index and walk error).
// ----------------------------------------------------------------------------
`default_nettype none

interface bpl_in_if import bpl_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [ENTRY_W-1:0]        entry_index;
	logic signed [COORD_W-1:0] line_origin_x;
	logic signed [COORD_W-1:0] line_origin_y;
	logic signed [COORD_W-1:0] line_delta_x;
	logic signed [COORD_W-1:0] line_delta_y;
	logic [REF_W-1:0]          front_reference;
	logic [REF_W-1:0]          back_reference;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;

	modport source (
		output valid, func, entry_index, line_origin_x, line_origin_y,
		       line_delta_x, line_delta_y, front_reference, back_reference,
		       point_x, point_y,
		input  ready
	);
	modport sink (
		input  valid, func, entry_index, line_origin_x, line_origin_y,
		       line_delta_x, line_delta_y, front_reference, back_reference,
		       point_x, point_y,
		output ready
	);
endinterface

interface bpl_out_if import bpl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [LEAF_W-1:0] leaf_index;
	logic              walk_error;

	modport source (output valid, leaf_index, walk_error, input ready);
	modport sink (input valid, leaf_index, walk_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bsp_point_locate_core.sv =====
// ----------------------------------------------------------------------------
// BSP point locate core
// Stores BSP partition nodes and walks the tree for a 16.16 fixed-point
// query point, one node at a time, returning the leaf that holds the point.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Word
// item      in         node write (func 0) or point query (func 1)
// result    out        leaf_index and walk_error, one per query
// apb       in/out     root_reference register at byte address 0
//
// A node write is taken and written to the node RAM at the same edge.
// A query is taken in the idle step, then each visited node is read from
// the RAM and evaluated; when the side does not settle directly, the
// shared 32 x 16 multiplier is used twice before a compare step.
// The node RAM read and the single multiplier set the step length.
// Reset clears the sequencer and result register; root_reference goes to
// leaf 0; the node RAM is not cleared and must be written before it is walked.
// A finished query waits in the finish step while the result register is
// still full; the item channel is open again once the word moves across.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_point_locate_core import bpl_pkg::*; #(
	parameter int NODE_CAPACITY = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready,
	bpl_in_if.sink                     item,
	bpl_out_if.source                  result
);

	localparam int ADDR_W = $clog2(NODE_CAPACITY);
	localparam logic [REF_W:0] CAPACITY = (REF_W+1)'(NODE_CAPACITY);

	// Sequencer steps.
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_EVAL   = 3'd2;
	localparam logic [2:0] ST_MUL1   = 3'd3;
	localparam logic [2:0] ST_MUL2   = 3'd4;
	localparam logic [2:0] ST_CMP    = 3'd5;
	localparam logic [2:0] ST_FINISH = 3'd6;

	logic [2:0]                state_q;
	logic [REF_W-1:0]          root_q;
	logic [REF_W-1:0]          ref_q;
	logic [REF_W-1:0]          visits_q;
	logic [REF_W-1:0]          limit_q;
	logic signed [COORD_W-1:0] px_q, py_q;
	logic [LEAF_W-1:0]         leaf_q;
	logic                      error_q;
	logic                      out_valid_q;
	logic [LEAF_W-1:0]         out_leaf_q;
	logic                      out_error_q;

	logic                      item_take, item_locate, item_write;
	logic [REF_W:0]            wr_slot;
	logic                      ram_we, ram_re;
	logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
	node_t                     wr_node, rd_node;
	logic [NODE_W-1:0]         ram_rdata;
	logic                      walk_bad, is_leaf, finish_load;
	logic [REF_W-1:0]          next_ref;
	side_ctl_t                 side_ctl;
	side_res_t                 side_res;

	// ------------------------------------------------------------------
	// Configuration port: a single register, written on the access cycle.
	// ------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= ROOT_RESET;
		end else if (psel && penable && pwrite && paddr == REG_ROOT) begin
			root_q <= pwdata[REF_W-1:0];
		end
	end

	assign prdata = (paddr == REG_ROOT) ? APB_DATA_W'(root_q) : '0;

	// ------------------------------------------------------------------
	// Node RAM. Writes whose slot lies beyond the table are dropped.
	// ------------------------------------------------------------------
	assign item.ready  = (state_q == ST_IDLE);
	assign item_take   = item.valid && item.ready;
	assign item_locate = item_take && item.func == FUNC_LOCATE;
	assign item_write  = item_take && item.func == FUNC_WRITE;

	assign wr_slot   = (REF_W+1)'(item.entry_index);
	assign ram_we    = item_write && (wr_slot < CAPACITY);
	assign ram_waddr = wr_slot[ADDR_W-1:0];

	assign wr_node.origin_x  = item.line_origin_x;
	assign wr_node.origin_y  = item.line_origin_y;
	assign wr_node.delta_x   = item.line_delta_x;
	assign wr_node.delta_y   = item.line_delta_y;
	assign wr_node.front_ref = item.front_reference;
	assign wr_node.back_ref  = item.back_reference;

	// The walk fails on a node reference past the table, or when it would
	// visit more nodes than the root index implies the tree holds.
	assign is_leaf  = ref_q[LEAF_BIT];
	assign walk_bad = ({1'b0, ref_q} >= CAPACITY) || (visits_q >= limit_q);
	assign ram_re   = (state_q == ST_CHECK) && !is_leaf && !walk_bad;
	assign ram_raddr = ref_q[ADDR_W-1:0];

	bpl_ram #(
		.WIDTH (NODE_W),
		.DEPTH (NODE_CAPACITY)
	) u_node_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_node),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The RAM output holds between reads, so the node stays put through the
	// multiply steps.
	assign rd_node = ram_rdata;

	// ------------------------------------------------------------------
	// Side unit and child selection.
	// ------------------------------------------------------------------
	assign side_ctl.eval       = (state_q == ST_EVAL);
	assign side_ctl.mul_first  = (state_q == ST_MUL1);
	assign side_ctl.mul_second = (state_q == ST_MUL2);

	bpl_side u_side (
		.clk  (clk),
		.ctl  (side_ctl),
		.node (rd_node),
		.px   (px_q),
		.py   (py_q),
		.res  (side_res)
	);

	assign next_ref = side_res.side ? rd_node.back_ref : rd_node.front_ref;

	assign finish_load = (state_q == ST_FINISH) && (!out_valid_q || result.ready);

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_locate) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (is_leaf || walk_bad) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= side_res.direct ? ST_CHECK : ST_MUL1;
				end
				ST_MUL1: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= ST_CHECK;
				end
				ST_FINISH: begin
					if (finish_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk registers; the sequencer state alone tells whether they matter.
	always_ff @(posedge clk) begin
		if (item_locate) begin
			px_q     <= item.point_x;
			py_q     <= item.point_y;
			ref_q    <= root_q;
			visits_q <= '0;
			limit_q  <= {1'b0, root_q[LEAF_W-1:0]} + REF_W'(1);
		end
		if (state_q == ST_CHECK) begin
			if (is_leaf) begin
				leaf_q  <= ref_q[LEAF_W-1:0];
				error_q <= 1'b0;
			end else if (walk_bad) begin
				leaf_q  <= '0;
				error_q <= 1'b1;
			end else begin
				visits_q <= visits_q + REF_W'(1);
			end
		end
		if ((state_q == ST_EVAL && side_res.direct) || state_q == ST_CMP) begin
			ref_q <= next_ref;
		end
		if (finish_load) begin
			out_leaf_q  <= leaf_q;
			out_error_q <= error_q;
		end
	end

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.leaf_index = out_leaf_q;
	assign result.walk_error = out_error_q;

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	a_error_means_leaf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.walk_error |-> result.leaf_index == '0)
		else $error("walk error word carries a non-zero leaf index");

	a_visits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> visits_q <= limit_q && visits_q != '0)
		else $error("node visit count outside its limit");

	a_query_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		item_locate |=> state_q == ST_CHECK && ref_q == $past(root_q))
		else $error("query did not start at the root reference");

	a_products_follow_eval: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL1 |-> $past(state_q) == ST_EVAL && !$past(side_res.direct))
		else $error("multiply step entered without an undecided evaluate step");

	a_no_write_during_walk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !ram_we)
		else $error("node RAM written while a walk runs");

endmodule

`default_nettype wire

// ===== rtl/core/bpl_ram.sv =====
// ----------------------------------------------------------------------------
// BSP point locate: generic RAM
// One write port and one read port, read data registered on a read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module bpl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bpl_side.sv =====
// ----------------------------------------------------------------------------
// BSP point locate: side unit
// Decides on which side of a node's partition line the point lies. Axis
// aligned lines and opposite sign cases settle at once; the general case
// runs two products through one shared 32 x 16 multiplier and compares them.
// ----------------------------------------------------------------------------
`default_nettype none

module bpl_side import bpl_pkg::*; (
	input  wire logic                      clk,
	input  wire side_ctl_t                 ctl,
	input  wire node_t                     node,
	input  wire logic signed [COORD_W-1:0] px,
	input  wire logic signed [COORD_W-1:0] py,
	output side_res_t                      res
);

	localparam int PROD_W = COORD_W + INT_W;

	logic signed [COORD_W-1:0] rx, ry;
	logic signed [COORD_W-1:0] rx_q, ry_q;
	logic signed [COORD_W-1:0] prod_a_q, prod_b_q;
	logic signed [COORD_W-1:0] mul_a;
	logic signed [INT_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic dx_zero, dy_zero, dx_pos, dy_pos, dx_neg, dy_neg;
	logic px_le_ox, py_le_oy, sign_mix, direct_side;

	assign rx = px - node.origin_x;
	assign ry = py - node.origin_y;

	assign dx_zero = (node.delta_x == '0);
	assign dy_zero = (node.delta_y == '0);
	assign dx_neg  = node.delta_x[COORD_W-1];
	assign dy_neg  = node.delta_y[COORD_W-1];
	assign dx_pos  = !dx_neg && !dx_zero;
	assign dy_pos  = !dy_neg && !dy_zero;
	assign px_le_ox = (px <= node.origin_x);
	assign py_le_oy = (py <= node.origin_y);

	assign sign_mix = node.delta_y[COORD_W-1] ^ node.delta_x[COORD_W-1]
	                ^ rx[COORD_W-1] ^ ry[COORD_W-1];

	always_comb begin
		if (dx_zero) begin
			direct_side = px_le_ox ? dy_pos : dy_neg;
		end else if (dy_zero) begin
			direct_side = py_le_oy ? dx_neg : dx_pos;
		end else begin
			direct_side = node.delta_y[COORD_W-1] ^ rx[COORD_W-1];
		end
	end

	// First product is ry times the integer part of dx, the second is the
	// integer part of dy times rx; each keeps bits 47:16 of the full product.
	assign mul_a = ctl.mul_first ? ry_q : rx_q;
	assign mul_b = ctl.mul_first ? node.delta_x[COORD_W-1 -: INT_W]
	                             : node.delta_y[COORD_W-1 -: INT_W];
	assign prod  = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			rx_q <= rx;
			ry_q <= ry;
		end
		if (ctl.mul_first) begin
			prod_a_q <= prod[PROD_W-1 -: COORD_W];
		end
		if (ctl.mul_second) begin
			prod_b_q <= prod[PROD_W-1 -: COORD_W];
		end
	end

	assign res.direct = dx_zero || dy_zero || sign_mix;
	assign res.side   = ctl.eval ? direct_side : (prod_a_q >= prod_b_q);

endmodule

`default_nettype wire

// ===== tb/bpl_locate_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BSP point locate: result checker
// Watches the item, result and register ports of the point locate core. It
// keeps its own node table and root reference, works out the leaf for every
// accepted query and compares each result word with the oldest answer due.
// ----------------------------------------------------------------------------

module bpl_locate_checker import bpl_pkg::*; #(
	parameter int NODE_CAPACITY = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic [APB_DATA_W-1:0] prdata,
	input  logic                  pready,
	bpl_in_if                     item,
	bpl_out_if                    result,
	output int                    fail_count,
	output int                    pending
);

	typedef struct packed {
		logic [LEAF_W-1:0] leaf;
		logic              err;
	} leaf_answer_t;

	node_t            node_table [NODE_CAPACITY];
	logic [REF_W-1:0] root_copy;
	leaf_answer_t     answers_due [$];

	initial begin
		fail_count = 0;
		pending    = 0;
		root_copy  = ROOT_RESET;
	end

	task automatic report(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// 16.16 product of a coordinate with an integer part, floored and wrapped.
	function automatic logic [COORD_W-1:0] scaled_product(input logic signed [COORD_W-1:0] a,
			input logic signed [INT_W-1:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		p = p >>> FRAC_W;
		return p[COORD_W-1:0];
	endfunction

	// 1 when the point lies on the back side of the node's partition line.
	function automatic logic back_side(input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py, input node_t nd);
		logic [COORD_W-1:0] rx, ry;
		if (nd.delta_x == '0)
			return ($signed(px) <= $signed(nd.origin_x)) ? ($signed(nd.delta_y) > 0)
			                                             : ($signed(nd.delta_y) < 0);
		if (nd.delta_y == '0)
			return ($signed(py) <= $signed(nd.origin_y)) ? ($signed(nd.delta_x) < 0)
			                                             : ($signed(nd.delta_x) > 0);
		rx = px - nd.origin_x;
		ry = py - nd.origin_y;
		// Opposite signs of the two cross terms settle the side without products.
		if (nd.delta_y[31] ^ nd.delta_x[31] ^ rx[31] ^ ry[31])
			return nd.delta_y[31] ^ rx[31];
		return $signed(scaled_product(ry, nd.delta_x[31:16]))
		       >= $signed(scaled_product(rx, nd.delta_y[31:16]));
	endfunction

	function automatic leaf_answer_t locate(input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py);
		logic [REF_W-1:0] cursor;
		int unsigned      visits, visit_limit;
		node_t            nd;
		cursor      = root_copy;
		visit_limit = root_copy[LEAF_W-1:0] + 1;
		visits      = 0;
		while (!cursor[LEAF_BIT]) begin
			if (cursor >= NODE_CAPACITY || visits >= visit_limit)
				return '{leaf: '0, err: 1'b1};
			visits++;
			nd     = node_table[cursor];
			cursor = back_side(px, py, nd) ? nd.back_ref : nd.front_ref;
		end
		return '{leaf: cursor[LEAF_W-1:0], err: 1'b0};
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		leaf_answer_t want;
		if (!arst_n) begin
			root_copy = ROOT_RESET;
		end else begin
			if (psel && penable && pready && paddr == REG_ROOT) begin
				if (pwrite)
					root_copy = pwdata[REF_W-1:0];
				else if (prdata[REF_W-1:0] !== root_copy)
					report($sformatf("root_reference read %h, expected %h",
					                 prdata[REF_W-1:0], root_copy));
			end

			if (result.valid && result.ready) begin
				if (answers_due.size() == 0) begin
					report($sformatf("result word leaf %0d err %0b with no query waiting",
					                 result.leaf_index, result.walk_error));
				end else begin
					want = answers_due.pop_front();
					if (result.leaf_index !== want.leaf || result.walk_error !== want.err)
						report($sformatf("leaf_index %0d walk_error %0b, expected %0d %0b",
						                 result.leaf_index, result.walk_error,
						                 want.leaf, want.err));
				end
			end

			if (item.valid && item.ready) begin
				if (item.func == FUNC_WRITE) begin
					if (item.entry_index < NODE_CAPACITY)
						node_table[item.entry_index] = '{
							origin_x:  item.line_origin_x,
							origin_y:  item.line_origin_y,
							delta_x:   item.line_delta_x,
							delta_y:   item.line_delta_y,
							front_ref: item.front_reference,
							back_ref:  item.back_reference
						};
				end else begin
					answers_due.push_back(locate(item.point_x, item.point_y));
				end
			end
			pending = answers_due.size();
		end
	end

endmodule

// ===== tb/tb_bsp_point_locate_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BSP point locate core: testbench
// Builds small partition trees in the node table, sets the root reference
// over the register port and sends point queries, first a directed set and
// then random trees and points with random idling on both channels. The
// checker beside the block predicts every answer and counts mismatches.
// ----------------------------------------------------------------------------

module tb_bsp_point_locate_core;

	import bpl_pkg::*;

	localparam int NODE_CAPACITY = 4096;
	// Cycles left after the last answer before a register write or the verdict.
	localparam int SETTLE_CYCLES = 24;
	// Length of the one long stall of the result side.
	localparam int LONG_HOLD     = 200;
	localparam int TOTAL_ITEMS   = 450;
	localparam int DRAIN_LIMIT   = 200000;
	localparam int RUN_LIMIT_NS  = 4000000;

	localparam logic signed [COORD_W-1:0] FX_ONE = 32'sh0001_0000;
	localparam logic signed [COORD_W-1:0] FX_MIN = 32'sh8000_0000;
	localparam logic signed [COORD_W-1:0] FX_MAX = 32'sh7FFF_FFFF;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int fail_count;
	int pending;

	// Idling switches, redrawn for every phase so that some phases run flat out.
	bit send_idle;
	bit take_idle;
	// Set by the stimulus, cleared by the result side once it starts its long stall.
	bit hold_req;
	// Nodes of the tree in use: slots 0 .. tree_nodes-1 are all written.
	int tree_nodes;
	int items_sent;

	bpl_in_if  item_ch ();
	bpl_out_if res_ch ();

	bsp_point_locate_core #(.NODE_CAPACITY(NODE_CAPACITY)) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_ch),
		.result  (res_ch)
	);

	bpl_locate_checker #(.NODE_CAPACITY(NODE_CAPACITY)) u_locate_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.item       (item_ch),
		.result     (res_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Safety net: the slowest correct run is far shorter than this.
	initial begin
		#(RUN_LIMIT_NS);
		$display("== FAIL ==");
		$finish;
	end

	// Coordinates: extremes, full random words, a coarse integer grid (so that
	// points often sit exactly on a line) and small fractional values.
	function automatic logic signed [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 5)) inside
			0:       return $urandom_range(0, 1) ? FX_MAX : FX_MIN;
			1, 2:    return $urandom();
			3, 4:    return (int'($urandom_range(0, 16)) - 8) * FX_ONE;
			default: return int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
		endcase
	endfunction

	// Directions are zero now and then, which gives vertical and horizontal lines.
	function automatic logic signed [COORD_W-1:0] pick_delta();
		if ($urandom_range(0, 5) == 0)
			return '0;
		return pick_coord();
	endfunction

	// Children are mostly leaves or lower slots, so most walks are well formed;
	// a few point anywhere in the tree (loops) or past the table.
	function automatic logic [REF_W-1:0] pick_child(input int slot);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 42 || (roll < 88 && slot == 0))
			return 16'h8000 | REF_W'($urandom_range(0, 16'h7FFF));
		if (roll < 88)
			return REF_W'($urandom_range(0, slot - 1));
		if (roll < 94)
			return REF_W'($urandom_range(0, tree_nodes - 1));
		return REF_W'($urandom_range(NODE_CAPACITY, 16'h7FFF));
	endfunction

	function automatic node_t pick_node(input int slot);
		node_t nd;
		nd.origin_x  = pick_coord();
		nd.origin_y  = pick_coord();
		nd.delta_x   = pick_delta();
		nd.delta_y   = pick_delta();
		nd.front_ref = pick_child(slot);
		nd.back_ref  = pick_child(slot);
		return nd;
	endfunction

	// A root is a written node, a leaf, or a node reference past the table.
	function automatic logic [REF_W-1:0] pick_root();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return REF_W'(tree_nodes - 1);
		if (roll < 80)
			return REF_W'($urandom_range(0, tree_nodes - 1));
		if (roll < 90)
			return 16'h8000 | REF_W'($urandom_range(0, 16'h7FFF));
		return REF_W'($urandom_range(NODE_CAPACITY, 16'h7FFF));
	endfunction

	// Offers one word on the item channel after a drawn gap and returns once it
	// has been taken. Inputs change on the falling edge only.
	task automatic send_word(input logic fn, input logic [ENTRY_W-1:0] slot,
			input node_t nd, input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py);
		int gap;
		gap = send_idle ? $urandom_range(0, 3) : 0;
		@(negedge clk);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid           <= 1'b1;
		item_ch.func            <= fn;
		item_ch.entry_index     <= slot;
		item_ch.line_origin_x   <= nd.origin_x;
		item_ch.line_origin_y   <= nd.origin_y;
		item_ch.line_delta_x    <= nd.delta_x;
		item_ch.line_delta_y    <= nd.delta_y;
		item_ch.front_reference <= nd.front_ref;
		item_ch.back_reference  <= nd.back_ref;
		item_ch.point_x         <= px;
		item_ch.point_y         <= py;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
	endtask

	task automatic write_node(input int slot, input node_t nd);
		send_word(FUNC_WRITE, ENTRY_W'(slot), nd, pick_coord(), pick_coord());
	endtask

	// The node fields of a query are noise; the block must ignore them.
	task automatic query_point(input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py);
		send_word(FUNC_LOCATE, ENTRY_W'($urandom()), pick_node(0), px, py);
	endtask

	// Drops valid and waits until every answer is in and the block has settled.
	task automatic drain_block(input int max_cycles);
		int waited;
		waited = 0;
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending != 0 && waited < max_cycles) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register transfer: setup on one falling edge, access on the next,
	// done at the rising edge where pready is high. psel stays up afterwards,
	// so that back-to-back transfers need no second assignment in one step.
	task automatic apb_transfer(input logic wr, input logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= REG_ROOT;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// Writes root_reference while the block is idle and reads it back; the
	// checker compares the read data.
	task automatic set_root(input logic [REF_W-1:0] root);
		drain_block(DRAIN_LIMIT);
		apb_transfer(1'b1, APB_DATA_W'(root));
		apb_transfer(1'b0, '0);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Result side: a drawn stall before each word, and one long stall on
	// request while the item side keeps offering queries, so that the block
	// fills up and closes its input.
	initial begin : result_side
		int gap;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				gap = take_idle ? $urandom_range(0, 3) : 0;
				if (gap != 0) begin
					res_ch.ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	initial begin : stimulus
		int phase;
		int slot;
		arst_n                  = 1'b0;
		psel                    = 1'b0;
		penable                 = 1'b0;
		pwrite                  = 1'b0;
		paddr                   = '0;
		pwdata                  = '0;
		item_ch.valid           = 1'b0;
		item_ch.func            = FUNC_WRITE;
		item_ch.entry_index     = '0;
		item_ch.line_origin_x   = '0;
		item_ch.line_origin_y   = '0;
		item_ch.line_delta_x    = '0;
		item_ch.line_delta_y    = '0;
		item_ch.front_reference = '0;
		item_ch.back_reference  = '0;
		item_ch.point_x         = '0;
		item_ch.point_y         = '0;
		send_idle               = 1'b0;
		take_idle               = 1'b0;
		hold_req                = 1'b0;
		tree_nodes              = 6;
		items_sent              = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed part. Straight after reset the root is leaf 0.
		query_point(FX_MIN, FX_MAX);

		// Node 0 is a vertical line, node 1 a horizontal one, node 2 a general
		// line; node 3 leads out of the table on both sides and node 4 loops
		// back on itself on its front side. Slot 4095 carries the extremes.
		write_node(0, '{origin_x: 0, origin_y: 0, delta_x: 0, delta_y: FX_ONE,
		                front_ref: 16'h8001, back_ref: 16'h8002});
		write_node(1, '{origin_x: 0, origin_y: 5 * FX_ONE, delta_x: -FX_ONE, delta_y: 0,
		                front_ref: 16'h8003, back_ref: 16'h0000});
		write_node(2, '{origin_x: FX_ONE, origin_y: FX_ONE, delta_x: 3 * FX_ONE,
		                delta_y: 2 * FX_ONE, front_ref: 16'h0001, back_ref: 16'h8004});
		write_node(3, '{origin_x: FX_ONE, origin_y: -FX_ONE, delta_x: FX_ONE,
		                delta_y: -2 * FX_ONE, front_ref: 16'h1000, back_ref: 16'h7FFF});
		write_node(4, '{origin_x: 0, origin_y: 0, delta_x: 0, delta_y: -FX_ONE,
		                front_ref: 16'h0004, back_ref: 16'h8005});
		write_node(4095, '{origin_x: FX_MAX, origin_y: FX_MIN, delta_x: FX_MIN,
		                   delta_y: FX_MAX, front_ref: 16'hFFFF, back_ref: 16'h0002});

		// Walks through the general, horizontal and vertical tests, including
		// points exactly on a line and the sign shortcut.
		set_root(16'h0002);
		query_point(2 * FX_ONE, FX_ONE);
		query_point(-3 * FX_ONE, 7 * FX_ONE);
		query_point(0, 0);
		query_point(FX_ONE, FX_ONE);
		query_point(FX_MAX, FX_MIN);
		query_point(-2 * FX_ONE, 4 * FX_ONE);

		// Children past the table end the walk with an error.
		set_root(16'h0003);
		query_point(-FX_ONE, -FX_ONE);
		query_point(5 * FX_ONE, 5 * FX_ONE);

		// A self loop runs past the visit limit; the other side finds leaf 5.
		set_root(16'h0004);
		query_point(-FX_ONE, 0);
		query_point(FX_ONE, 0);

		set_root(16'h0FFF);
		query_point(0, 0);
		query_point(FX_MIN, FX_MIN);

		// A root node reference past the table, a leaf root and the lowest root.
		set_root(16'h7FFF);
		query_point(0, FX_ONE);
		set_root(16'hFFFF);
		query_point(FX_ONE, 0);
		set_root(16'h0000);
		query_point(-FX_ONE, 0);

		// Random part: each phase writes a fresh tree, picks a root and sends a
		// burst of queries with the odd node write mixed in.
		phase = 0;
		while (items_sent < TOTAL_ITEMS) begin
			drain_block(DRAIN_LIMIT);
			send_idle  = $urandom_range(0, 3) != 0;
			take_idle  = $urandom_range(0, 3) != 0;
			tree_nodes = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
			                                          : $urandom_range(2, 16);
			for (slot = 0; slot < tree_nodes; slot++)
				write_node(slot, pick_node(slot));
			set_root(pick_root());
			if (phase == 2)
				hold_req = 1'b1;
			repeat ($urandom_range(8, 30)) begin
				if ($urandom_range(0, 9) == 0) begin
					slot = $urandom_range(0, NODE_CAPACITY - 1);
					write_node(slot, pick_node(slot));
				end else begin
					query_point(pick_coord(), pick_coord());
				end
			end
			phase++;
		end

		drain_block(DRAIN_LIMIT);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== bsp_point_locate_core.f =====
rtl/core/bpl_pkg.sv
rtl/core/bpl_if.sv
rtl/core/bpl_ram.sv
rtl/core/bpl_side.sv
rtl/core/bsp_point_locate_core.sv
tb/bpl_locate_checker.sv
tb/tb_bsp_point_locate_core.sv
